### sv/bmp_pkg.sv
// Shared constants and request/response types for the binomial mod prime block.
`timescale 1ns / 1ps

package bmp_pkg;

    // Field and arithmetic widths
    localparam int DATA_W = 30;
    localparam int TOP_W = 16;
    localparam int CHOOSE_W = 17;
    localparam int PROD_W = 2 * DATA_W;

    // Default table depth
    localparam int DEF_TABLE_SIZE = 65536;

    // Modulus and the Fermat exponent for the inverse
    localparam logic [DATA_W-1:0] PRIME = 30'd998244353;
    localparam logic [DATA_W-1:0] EXP_INV = PRIME - 30'd2;

    // Barrett constant floor(2^60 / p), worked out at elaboration
    localparam logic [63:0] MU_WIDE = (64'd1 << PROD_W) / {34'd0, PRIME};
    localparam logic [DATA_W:0] MU = MU_WIDE[DATA_W:0];

    // Pipeline depth of the modular multiplier
    localparam int MUL_LAT = 5;

    // Operands into the modular multiplier
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } mm_req_t;

    // Product out of the modular multiplier
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] r;
    } mm_rsp_t;

endpackage

### sv/bmp_mulmod.sv
// Five-stage pipelined a*b mod p multiplier using Barrett reduction.
`timescale 1ns / 1ps

module bmp_mulmod (
    input  logic            clk,
    input  logic            rst_n,
    input  bmp_pkg::mm_req_t req,
    output bmp_pkg::mm_rsp_t rsp
);
    import bmp_pkg::*;

    localparam logic [31:0] PRIME_X1 = {2'b00, PRIME};
    localparam logic [31:0] PRIME_X2 = {1'b0, PRIME, 1'b0};

    logic [MUL_LAT-1:0]  v_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [PROD_W+1:0]   q1_reg;
    logic [PROD_W+1:0]   q1_next;
    logic [31:0]         x2_reg;
    logic [31:0]         x3_reg;
    logic [PROD_W:0]     qp_full;
    logic [31:0]         qp_reg;
    logic [31:0]         r_reg;
    logic [31:0]         r_next;
    logic [DATA_W-1:0]   res_reg;
    logic [DATA_W-1:0]   res_next;

    // Full product, then the quotient estimate, then q*p
    assign prod_next = req.a * req.b;
    assign q1_next = prod_reg[PROD_W-1:DATA_W-1] * MU;
    assign qp_full = q1_reg[PROD_W+1:DATA_W+1] * PRIME;
    // Remainder lies below 3p, so low 32 bits suffice
    assign r_next = x3_reg - qp_reg;

    // Fold the remainder into range with at most one subtract
    always_comb
    begin
        if (r_reg >= PRIME_X2)
        begin
            res_next = DATA_W'(r_reg - PRIME_X2);
        end
        else if (r_reg >= PRIME_X1)
        begin
            res_next = DATA_W'(r_reg - PRIME_X1);
        end
        else
        begin
            res_next = r_reg[DATA_W-1:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[MUL_LAT-2:0], req.valid};
        end
    end

    // Advance data stages
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        q1_reg   <= q1_next;
        x2_reg   <= prod_reg[31:0];
        qp_reg   <= qp_full[31:0];
        x3_reg   <= x2_reg;
        r_reg    <= r_next;
        res_reg  <= res_next;
    end

    assign rsp.valid = v_reg[MUL_LAT-1];
    assign rsp.r = res_reg;

endmodule

### sv/binomial_mod_prime.sv
// Top level: C(n,k) mod 998244353 from factorial and inverse factorial memories.
//
// Usage: drive top (n) and choose (k, signed) and raise start; the query is
// taken at a rising edge where start is high and busy is low. One query may
// be taken in every cycle. The answer appears on value with done high for
// exactly one cycle. The query passes the memory read on the edge that took
// it, then two chained five-stage modular multipliers and an output register.
// Answers come out in query order and cannot be held off.
// value is 0 when k is negative, k exceeds n, or n is not below TABLE_SIZE.
// After reset the block builds its tables and holds busy high meanwhile:
// it seeds 0!, then computes the factorials (TABLE_SIZE-1 entries), runs 30
// squaring steps for the Fermat power, and sweeps down the table for the
// inverses. The build is bounded by the latency of the modular multipliers,
// which are shared with the query path, since each entry needs the one
// before it.
`timescale 1ns / 1ps

module binomial_mod_prime #(
    parameter int TABLE_SIZE = bmp_pkg::DEF_TABLE_SIZE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bmp_pkg::TOP_W-1:0]     top,
    input  logic signed [bmp_pkg::CHOOSE_W-1:0] choose,
    output logic                          done,
    output logic [bmp_pkg::DATA_W-1:0]    value
);
    import bmp_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int CW = (IW + 1 > CHOOSE_W) ? IW + 1 : CHOOSE_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);
    localparam logic [CW-1:0] SIZE_C = CW'(TABLE_SIZE);

    // Build sequencer states
    localparam logic [2:0] ST_START = 3'd0;
    localparam logic [2:0] ST_FAC   = 3'd1;
    localparam logic [2:0] ST_POW   = 3'd2;
    localparam logic [2:0] ST_INV   = 3'd3;
    localparam logic [2:0] ST_READY = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [IW-1:0]     idx_reg;
    logic [IW-1:0]     idx_next;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;
    logic [DATA_W-1:0] base_reg;
    logic [DATA_W-1:0] base_next;
    logic [DATA_W-1:0] exp_reg;
    logic [DATA_W-1:0] exp_next;
    logic              pend_reg;
    logic              pend_next;
    logic [DATA_W-1:0] idx_ext;

    logic              fac_we;
    logic [IW-1:0]     fac_wa;
    logic [DATA_W-1:0] fac_wd;
    logic              ifac_we;
    logic [IW-1:0]     ifac_wa;
    logic [DATA_W-1:0] ifac_wd;

    mm_req_t init_req1;
    mm_req_t init_req2;
    mm_req_t m1_req;
    mm_req_t m2_req;
    mm_rsp_t m1_rsp;
    mm_rsp_t m2_rsp;

    logic [DATA_W-1:0] fac_mem  [TABLE_SIZE];
    logic [DATA_W-1:0] ifac_mem [TABLE_SIZE];

    logic              accept;
    logic [CW-1:0]     n_c;
    logic [CW-1:0]     k_c;
    logic [CW-1:0]     nk_c;
    logic              ok;
    logic [IW-1:0]     n_addr;
    logic [IW-1:0]     k_addr;
    logic [IW-1:0]     nk_addr;

    logic              q1_v_reg;
    logic              ok1_reg;
    logic [DATA_W-1:0] fac_rd_reg;
    logic [DATA_W-1:0] ifk_rd_reg;
    logic [DATA_W-1:0] ifnk_rd_reg;
    logic [DATA_W-1:0] nk_dly_reg [MUL_LAT];
    logic              ok_dly_reg [2*MUL_LAT];
    logic              done_reg;
    logic [DATA_W-1:0] value_reg;

    assign busy = (state_reg != ST_READY);
    assign idx_ext = {{(DATA_W-IW){1'b0}}, idx_reg};

    // Build sequencer: factorials up, Fermat power, inverses down
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        pend_next  = pend_reg;
        init_req1  = '0;
        init_req2  = '0;
        fac_we     = 1'b0;
        fac_wa     = idx_reg;
        fac_wd     = m1_rsp.r;
        ifac_we    = 1'b0;
        ifac_wa    = idx_reg;
        ifac_wd    = m1_rsp.r;
        case (state_reg)
            ST_START:
            begin
                fac_we     = 1'b1;
                fac_wa     = '0;
                fac_wd     = DATA_W'(1);
                acc_next   = DATA_W'(1);
                idx_next   = IW'(1);
                pend_next  = 1'b0;
                state_next = ST_FAC;
            end
            ST_FAC:
            begin
                if (!pend_reg)
                begin
                    init_req1.valid = 1'b1;
                    init_req1.a     = acc_reg;
                    init_req1.b     = idx_ext;
                    pend_next       = 1'b1;
                end
                else if (m1_rsp.valid)
                begin
                    fac_we    = 1'b1;
                    acc_next  = m1_rsp.r;
                    pend_next = 1'b0;
                    if (idx_reg == LAST_IDX)
                    begin
                        acc_next   = DATA_W'(1);
                        base_next  = m1_rsp.r;
                        exp_next   = EXP_INV;
                        state_next = ST_POW;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            ST_POW:
            begin
                if (!pend_reg)
                begin
                    init_req1.valid = 1'b1;
                    init_req1.a     = acc_reg;
                    init_req1.b     = exp_reg[0] ? base_reg : DATA_W'(1);
                    init_req2.valid = 1'b1;
                    init_req2.a     = base_reg;
                    init_req2.b     = base_reg;
                    exp_next        = exp_reg >> 1;
                    pend_next       = 1'b1;
                end
                else if (m1_rsp.valid)
                begin
                    acc_next  = m1_rsp.r;
                    base_next = m2_rsp.r;
                    pend_next = 1'b0;
                    if (exp_reg == '0)
                    begin
                        ifac_we    = 1'b1;
                        ifac_wa    = LAST_IDX;
                        idx_next   = LAST_IDX;
                        state_next = ST_INV;
                    end
                end
            end
            ST_INV:
            begin
                if (!pend_reg)
                begin
                    init_req1.valid = 1'b1;
                    init_req1.a     = acc_reg;
                    init_req1.b     = idx_ext;
                    pend_next       = 1'b1;
                end
                else if (m1_rsp.valid)
                begin
                    ifac_we   = 1'b1;
                    ifac_wa   = idx_reg - IW'(1);
                    acc_next  = m1_rsp.r;
                    pend_next = 1'b0;
                    if (idx_reg == IW'(1))
                    begin
                        state_next = ST_READY;
                    end
                    else
                    begin
                        idx_next = idx_reg - IW'(1);
                    end
                end
            end
            ST_READY:
            begin
                state_next = ST_READY;
            end
            default:
            begin
                state_next = ST_START;
            end
        endcase
    end

    // Hold sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    // Hold sequencer data
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
    end

    // Check ranges and form the three addresses of a query
    assign accept = start && !busy;
    assign n_c = CW'(top);
    assign k_c = CW'(choose[CHOOSE_W-2:0]);
    assign nk_c = n_c - k_c;
    assign ok = !choose[CHOOSE_W-1] && (k_c <= n_c) && (n_c < SIZE_C);
    assign n_addr = n_c[IW-1:0];
    assign k_addr = k_c[IW-1:0];
    assign nk_addr = nk_c[IW-1:0];

    // Factorial memory: build writes, one registered read
    always_ff @(posedge clk)
    begin
        if (fac_we)
        begin
            fac_mem[fac_wa] <= fac_wd;
        end
        fac_rd_reg <= fac_mem[n_addr];
    end

    // Inverse factorial memory: build writes, two registered reads
    always_ff @(posedge clk)
    begin
        if (ifac_we)
        begin
            ifac_mem[ifac_wa] <= ifac_wd;
        end
        ifk_rd_reg  <= ifac_mem[k_addr];
        ifnk_rd_reg <= ifac_mem[nk_addr];
    end

    // Share the multipliers between the build and the query path
    always_comb
    begin
        if (busy)
        begin
            m1_req = init_req1;
            m2_req = init_req2;
        end
        else
        begin
            m1_req.valid = q1_v_reg;
            m1_req.a     = fac_rd_reg;
            m1_req.b     = ifk_rd_reg;
            m2_req.valid = m1_rsp.valid;
            m2_req.a     = m1_rsp.r;
            m2_req.b     = nk_dly_reg[MUL_LAT-1];
        end
    end

    bmp_mulmod u_mul_first (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (m1_req),
        .rsp   (m1_rsp)
    );

    bmp_mulmod u_mul_second (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (m2_req),
        .rsp   (m2_rsp)
    );

    // Track query valid and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            q1_v_reg <= accept;
            done_reg <= m2_rsp.valid && !busy;
        end
    end

    // Delay the second inverse and the range flag alongside the multipliers
    always_ff @(posedge clk)
    begin
        ok1_reg       <= ok;
        nk_dly_reg[0] <= ifnk_rd_reg;
        for (int i = 1; i < MUL_LAT; i++)
        begin
            nk_dly_reg[i] <= nk_dly_reg[i-1];
        end
        ok_dly_reg[0] <= ok1_reg;
        for (int i = 1; i < 2 * MUL_LAT; i++)
        begin
            ok_dly_reg[i] <= ok_dly_reg[i-1];
        end
        value_reg <= ok_dly_reg[2*MUL_LAT-1] ? m2_rsp.r : '0;
    end

    assign done = done_reg;
    assign value = value_reg;

endmodule
